// File: design/cddr_pkg.sv
package cddr_pkg;

  localparam int unsigned CELL_CAPACITY = 16384;
  localparam int unsigned IDX_W         = $clog2(CELL_CAPACITY);
  localparam int unsigned CNT_W         = IDX_W + 1;
  localparam int unsigned RANGE_LIMIT   = 64;
  localparam int unsigned RTOT_W        = 7;

  localparam int unsigned IN_TDATA_W    = 96;
  localparam int unsigned OUT_TDATA_W   = 48;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W    = FIFO_PTR_W + 1;
  localparam int unsigned MAX_RESULTS   = 3;

  localparam logic [15:0]       BRIGHT_THR_RST = 16'd131;
  localparam logic [9:0]        RANGE_GAP_RST  = 10'd16;
  localparam logic [RTOT_W-1:0] MAX_RANGES_RST = 7'd64;

  typedef enum logic [1:0] {
    CFG_BRIGHT_THR = 2'd0,
    CFG_RANGE_GAP  = 2'd1,
    CFG_MAX_RANGES = 2'd2
  } cfg_index_e;

  typedef enum logic {
    KIND_RANGE   = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_e;

  // flags: bit0 selected, bit1 own color, bit2 quiet
  typedef struct packed {
    logic [15:0] glyph;
    logic [15:0] prev_glyph;
    logic [31:0] birth;
    logic [15:0] bright;
    logic [2:0]  flags;
    logic [23:0] rgb;
  } shadow_entry_t;

  typedef struct packed {
    logic             changed;
    logic             last;
    logic             freset;
    logic [IDX_W-1:0] idx;
  } cell_event_t;

  typedef struct packed {
    result_kind_e     kind;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] last_index;
    logic             full_upload;
    logic [CNT_W-1:0] dirty_count;
    logic             end_of_run;
  } result_t;

endpackage

// File: design/cddr_shadow_mem.sv
module cddr_shadow_mem
  import cddr_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  shadow_entry_t    wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output shadow_entry_t    rdata_o
);

  shadow_entry_t mem [CELL_CAPACITY];
  shadow_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read-before-write on a shared address; the caller forwards
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/cddr_range_trk.sv
module cddr_range_trk
  import cddr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  cell_event_t       evt_i,
  input  logic [9:0]        range_gap_i,
  input  logic [RTOT_W-1:0] max_ranges_i,
  output result_t           res_o [MAX_RESULTS],
  output logic [1:0]        res_n_o
);

  logic             open_q, open_d;
  logic [IDX_W-1:0] start_q, start_d;
  logic [IDX_W-1:0] end_q, end_d;
  logic [RTOT_W-1:0] total_q, total_d;
  logic             ff_q, ff_d;
  logic [CNT_W-1:0] ct_q, ct_d;

  logic [RTOT_W-1:0] limit;
  logic              gap_close, emit0, emit1;
  logic              open1, ff1, ff2;
  logic [IDX_W-1:0]  start1, end1;
  logic [RTOT_W-1:0] total1;
  logic [CNT_W-1:0]  ct1;
  result_t           cand [MAX_RESULTS];
  logic [MAX_RESULTS-1:0] emit;

  always_comb begin
    limit = (max_ranges_i < RTOT_W'(RANGE_LIMIT)) ? max_ranges_i : RTOT_W'(RANGE_LIMIT);

    // a changed cell too far past the open range closes it first
    gap_close = evt_i.changed && open_q &&
                ({1'b0, evt_i.idx} > ({1'b0, end_q} + CNT_W'(range_gap_i)));
    emit0  = gap_close && (total_q < limit);
    ff1    = ff_q || evt_i.freset || (gap_close && !emit0);
    total1 = emit0 ? total_q + RTOT_W'(1) : total_q;
    open1  = open_q || evt_i.changed;
    start1 = (evt_i.changed && (!open_q || gap_close)) ? evt_i.idx : start_q;
    end1   = evt_i.changed ? evt_i.idx : end_q;
    ct1    = (evt_i.changed && (ct_q < CNT_W'(CELL_CAPACITY))) ? ct_q + CNT_W'(1) : ct_q;

    // last cell flushes whatever range is still open
    emit1 = evt_i.last && open1 && (total1 < limit);
    ff2   = ff1 || (evt_i.last && open1 && !(total1 < limit));

    cand[0] = '{kind: KIND_RANGE, first_index: start_q, last_index: end_q,
                full_upload: 1'b0, dirty_count: '0, end_of_run: !evt_i.last};
    cand[1] = '{kind: KIND_RANGE, first_index: start1, last_index: end1,
                full_upload: 1'b0, dirty_count: '0, end_of_run: 1'b0};
    cand[2] = '{kind: KIND_SUMMARY, first_index: '0, last_index: '0,
                full_upload: ff2,
                dirty_count: ff2 ? ({1'b0, evt_i.idx} + CNT_W'(1)) : ct1,
                end_of_run: 1'b1};
    emit = {evt_i.last, emit1, emit0};
  end

  // pack emitted results to the front
  always_comb begin
    logic [1:0] k;
    k = '0;
    for (int j = 0; j < MAX_RESULTS; j++) begin
      res_o[j] = cand[j];
    end
    for (int j = 0; j < MAX_RESULTS; j++) begin
      if (emit[j]) begin
        res_o[k] = cand[j];
        k = k + 2'd1;
      end
    end
    res_n_o = k;
  end

  always_comb begin
    if (evt_i.last) begin
      open_d  = 1'b0;
      start_d = '0;
      end_d   = '0;
      total_d = '0;
      ff_d    = 1'b0;
      ct_d    = '0;
    end else begin
      open_d  = open1;
      start_d = start1;
      end_d   = end1;
      total_d = total1;
      ff_d    = ff1;
      ct_d    = ct1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      start_q <= '0;
      end_q   <= '0;
      total_q <= '0;
      ff_q    <= 1'b0;
      ct_q    <= '0;
    end else if (step_i) begin
      open_q  <= open_d;
      start_q <= start_d;
      end_q   <= end_d;
      total_q <= total_d;
      ff_q    <= ff_d;
      ct_q    <= ct_d;
    end
  end

endmodule

// File: design/cddr_res_fifo.sv
module cddr_res_fifo
  import cddr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  result_t               push_i [MAX_RESULTS],
  input  logic [1:0]            push_n_i,
  output logic [FIFO_CNT_W-1:0] count_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output result_t               data_o
);

  result_t                entries_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0]  count_q;
  logic                   pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = entries_q[rd_ptr_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_RESULTS; j++) begin
      if (2'(j) < push_n_i) begin
        entries_q[wr_ptr_q + FIFO_PTR_W'(j)] <= push_i[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_n_i);
      rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(pop);
      count_q  <= count_q + FIFO_CNT_W'(push_n_i) - FIFO_CNT_W'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> (count_q <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS)))
    else $error("results pushed without room for a full step");

endmodule

// File: design/cell_diff_dirty_range_tracker_unit.sv
// Cell diff and dirty-range tracker. Screen cells stream in on s_axis in index
// order, one transaction per cell, starting at index 0 after reset and after
// each transaction with tlast set. Each cell is compared with its entry in a
// 16384-entry shadow RAM (read when the cell is accepted, compared and written
// back when it retires, with a forwarding register for consecutive cells that
// share an entry). Changed cells merge into dirty ranges; a range goes out on
// m_axis when a later change lies more than range_gap past it or at the frame's
// last cell, which also sends a frame summary (tuser = 1). Throughput is one
// cell per cycle; the result side delivers one transaction per cycle from a
// 4-entry queue, and a cell is only retired while the queue can hold the three
// results it may cause, so cells stall when results pile up faster than the
// consumer takes them. After reset a clearing pass zeroes the shadow RAM, one
// entry per cycle, during which s_axis_tready stays low; configuration writes
// are taken at any time and should be issued while idle.
module cell_diff_dirty_range_tracker_unit
  import cddr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // cfg: index 0 bright_threshold, 1 range_gap, 2 max_ranges
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // tdata: glyph[15:0] brightness[31:16] sel_flag[32] color_flag[33]
  // quiet_request[34] fg_rgb[58:35] birth_time[90:59] bulk_repaint[91]
  // frame_reset[92], zero pad above; tlast: last_cell
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  // tdata: first_index[13:0] last_index[27:14] full_upload[28]
  // dirty_count[43:29], zero pad above; tuser: kind; tlast: end_of_run
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [0:0]             m_axis_tuser,
  output logic                   m_axis_tlast
);

  // configuration registers
  logic [15:0]       bright_thr_q;
  logic [9:0]        range_gap_q;
  logic [RTOT_W-1:0] max_ranges_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_thr_q <= BRIGHT_THR_RST;
      range_gap_q  <= RANGE_GAP_RST;
      max_ranges_q <= MAX_RANGES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_BRIGHT_THR: bright_thr_q <= cfg_data_i;
        CFG_RANGE_GAP:  range_gap_q  <= cfg_data_i[9:0];
        CFG_MAX_RANGES: max_ranges_q <= cfg_data_i[RTOT_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass after reset
  logic             clr_active_q;
  logic [IDX_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + IDX_W'(1);
      if (clr_addr_q == IDX_W'(CELL_CAPACITY - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // front: index counter and accept
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             accept;
  logic             s1_valid_q, s1_fire;
  logic [FIFO_CNT_W-1:0] fifo_count;

  assign s1_fire       = s1_valid_q && (fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS));
  assign s_axis_tready = !clr_active_q && (!s1_valid_q || s1_fire);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // stick at the last entry when a frame runs long
  assign idx_d = s_axis_tlast ? '0 :
                 (idx_q == IDX_W'(CELL_CAPACITY - 1)) ? idx_q : idx_q + IDX_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (accept) begin
      idx_q <= idx_d;
    end
  end

  // stage 1: compare and write back
  logic [IN_TDATA_W-1:0] s1_tdata_q;
  logic                  s1_last_q;
  logic [IDX_W-1:0]      s1_idx_q;
  logic                  fwd_hit_q;
  shadow_entry_t         fwd_data_q;
  shadow_entry_t         rd_data, old_e, new_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_tdata_q <= s_axis_tdata;
      s1_last_q  <= s_axis_tlast;
      s1_idx_q   <= idx_q;
      // the retiring cell writes the entry the new cell is reading
      fwd_hit_q  <= s1_fire && (s1_idx_q == idx_q);
      fwd_data_q <= new_e;
    end
  end

  logic [15:0] in_glyph, in_bright, bdiff;
  logic        in_sel, in_col, in_qreq, in_bulk, in_freset;
  logic [23:0] in_rgb;
  logic [31:0] in_birth;
  logic        glyph_chg, bright_chg, attr_chg, quiet;
  logic [2:0]  want;

  always_comb begin
    in_glyph  = s1_tdata_q[15:0];
    in_bright = s1_tdata_q[31:16];
    in_sel    = s1_tdata_q[32];
    in_col    = s1_tdata_q[33];
    in_qreq   = s1_tdata_q[34];
    in_rgb    = s1_tdata_q[58:35];
    in_birth  = s1_tdata_q[90:59];
    in_bulk   = s1_tdata_q[91];
    in_freset = s1_tdata_q[92];

    old_e = fwd_hit_q ? fwd_data_q : rd_data;

    glyph_chg  = (in_glyph != old_e.glyph);
    quiet      = glyph_chg ? (in_qreq && !in_bulk) : old_e.flags[2];
    bdiff      = (in_bright >= old_e.bright) ? in_bright - old_e.bright
                                             : old_e.bright - in_bright;
    bright_chg = (bdiff > bright_thr_q);
    want       = {quiet, in_col, in_sel};
    attr_chg   = (want != old_e.flags) || (in_rgb != old_e.rgb);

    new_e.glyph      = in_glyph;
    new_e.prev_glyph = glyph_chg ? old_e.glyph : old_e.prev_glyph;
    new_e.birth      = glyph_chg ? in_birth : old_e.birth;
    new_e.bright     = bright_chg ? in_bright : old_e.bright;
    new_e.flags      = want;
    new_e.rgb        = in_rgb;
  end

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  shadow_entry_t    mem_wdata;

  assign mem_we    = clr_active_q || s1_fire;
  assign mem_waddr = clr_active_q ? clr_addr_q : s1_idx_q;
  assign mem_wdata = clr_active_q ? '0 : new_e;

  cddr_shadow_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  // range tracking and result queue
  cell_event_t evt;
  result_t     step_res [MAX_RESULTS];
  logic [1:0]  step_n, push_n;
  result_t     head;

  assign evt = '{changed: glyph_chg || bright_chg || attr_chg,
                 last: s1_last_q, freset: in_freset, idx: s1_idx_q};

  cddr_range_trk u_trk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (s1_fire),
    .evt_i        (evt),
    .range_gap_i  (range_gap_q),
    .max_ranges_i (max_ranges_q),
    .res_o        (step_res),
    .res_n_o      (step_n)
  );

  assign push_n = s1_fire ? step_n : 2'd0;

  cddr_res_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (step_res),
    .push_n_i (push_n),
    .count_o  (fifo_count),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .data_o   (head)
  );

  assign m_axis_tdata = {4'b0, head.dirty_count, head.full_upload,
                         head.last_index, head.first_index};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.end_of_run;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !s_axis_tready)
    else $error("cell taken during shadow clear");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted cell lost before compare stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_fire) |=> ($stable(s1_idx_q) && s1_valid_q))
    else $error("stalled compare stage changed");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import cddr_pkg::*;

  // Quiet period allowed before the run is declared hung. The clearing pass
  // after reset alone keeps s_axis_tready low while it zeroes every shadow entry.
  localparam int unsigned QUIET_LIMIT  = 4 * CELL_CAPACITY + 4096;
  // Cycles to let pass after the last expected result before touching config
  // or ending the run: a cell with no result may still be in the pipeline.
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned GAP_MAX      = 19;

  // One screen cell as the sender holds it, plus its lead-in idle cycles.
  typedef struct {
    logic [15:0] glyph;
    logic [15:0] bright;
    logic        sel;
    logic        col;
    logic        quiet_req;
    logic [23:0] rgb;
    logic [31:0] birth;
    logic        bulk;
    logic        freset;
    logic        last;
    int unsigned gap;
  } screen_cell_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [1:0]             cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;
  logic                   m_axis_tlast;

  cell_diff_dirty_range_tracker_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the screen store and the frame's range bookkeeping
  // ---------------------------------------------------------------------------
  logic [15:0] sh_glyph      [CELL_CAPACITY];
  logic [15:0] sh_prev_glyph [CELL_CAPACITY];
  logic [31:0] sh_birth      [CELL_CAPACITY];
  logic [15:0] sh_bright     [CELL_CAPACITY];
  logic [2:0]  sh_flags      [CELL_CAPACITY];  // bit0 selected, bit1 color, bit2 quiet
  logic [23:0] sh_rgb        [CELL_CAPACITY];

  int unsigned cur_idx      = 0;
  bit          rng_open     = 1'b0;
  int unsigned rng_first    = 0;
  int unsigned rng_last     = 0;
  int unsigned rng_emitted  = 0;
  bit          full_forced  = 1'b0;
  int unsigned dirty_cells  = 0;

  logic [15:0]       cfg_bright_thr = BRIGHT_THR_RST;
  logic [9:0]        cfg_range_gap  = RANGE_GAP_RST;
  logic [RTOT_W-1:0] cfg_max_ranges = MAX_RANGES_RST;

  result_t step_reports[$];    // reports caused by the cell being diffed
  result_t upload_reports[$];  // reports still owed by the block, oldest first

  // Close the open dirty range. Past the range budget the range is dropped
  // and the frame falls back to a full upload.
  function automatic void close_dirty_range();
    int unsigned limit;
    result_t     r;
    limit = (cfg_max_ranges < RANGE_LIMIT) ? cfg_max_ranges : RANGE_LIMIT;
    if (rng_open) begin
      rng_open = 1'b0;
      if (rng_emitted < limit) begin
        rng_emitted++;
        r.kind        = KIND_RANGE;
        r.first_index = IDX_W'(rng_first);
        r.last_index  = IDX_W'(rng_last);
        r.full_upload = 1'b0;
        r.dirty_count = '0;
        r.end_of_run  = 1'b0;
        step_reports.insert(step_reports.size(), r);
      end else begin
        full_forced = 1'b1;
      end
    end
  endfunction

  // Diff one accepted cell against the shadow store, update ranges and queue
  // every report the cell causes.
  function automatic void diff_and_track(screen_cell_t c);
    int unsigned idx;
    int unsigned bdiff;
    bit          changed;
    logic [2:0]  quiet;
    logic [2:0]  want;
    result_t     r;
    idx     = cur_idx;
    changed = 1'b0;
    if (c.freset) full_forced = 1'b1;

    // The quiet bit is held until the next glyph change.
    quiet = sh_flags[idx] & 3'b100;
    if (c.glyph != sh_glyph[idx]) begin
      sh_prev_glyph[idx] = sh_glyph[idx];
      sh_glyph[idx]      = c.glyph;
      sh_birth[idx]      = c.birth;
      quiet              = {c.quiet_req & ~c.bulk, 2'b00};
      changed            = 1'b1;
    end
    bdiff = (c.bright >= sh_bright[idx]) ? c.bright - sh_bright[idx]
                                         : sh_bright[idx] - c.bright;
    if (bdiff > cfg_bright_thr) begin
      sh_bright[idx] = c.bright;
      changed        = 1'b1;
    end
    want = quiet | {1'b0, c.col, c.sel};
    if (want != sh_flags[idx] || c.rgb != sh_rgb[idx]) begin
      sh_flags[idx] = want;
      sh_rgb[idx]   = c.rgb;
      changed       = 1'b1;
    end

    if (changed) begin
      if (dirty_cells < CELL_CAPACITY) dirty_cells++;
      if (!rng_open) begin
        rng_open  = 1'b1;
        rng_first = idx;
      end else if (idx > rng_last + cfg_range_gap) begin
        close_dirty_range();
        rng_open  = 1'b1;
        rng_first = idx;
      end
      rng_last = idx;
    end

    if (c.last) begin
      close_dirty_range();
      r.kind        = KIND_SUMMARY;
      r.first_index = '0;
      r.last_index  = '0;
      r.full_upload = full_forced;
      r.dirty_count = CNT_W'(full_forced ? idx + 1 : dirty_cells);
      r.end_of_run  = 1'b0;
      step_reports.insert(step_reports.size(), r);
      cur_idx     = 0;
      rng_open    = 1'b0;
      rng_first   = 0;
      rng_last    = 0;
      rng_emitted = 0;
      full_forced = 1'b0;
      dirty_cells = 0;
    end else if (cur_idx < CELL_CAPACITY - 1) begin
      cur_idx++;
    end

    // Mark the final report of this cell and hand the batch to the checker.
    for (int k = 0; k < step_reports.size(); k++) begin
      r            = step_reports[k];
      r.end_of_run = (k == step_reports.size() - 1);
      upload_reports.insert(upload_reports.size(), r);
    end
    step_reports.delete();
  endfunction

  // ---------------------------------------------------------------------------
  // Failure bookkeeping
  // ---------------------------------------------------------------------------
  int unsigned fail_count = 0;

  function automatic string describe(result_t r);
    return $sformatf("kind=%0d first=%0d last=%0d full=%0d count=%0d end=%0d",
                     r.kind, r.first_index, r.last_index, r.full_upload,
                     r.dirty_count, r.end_of_run);
  endfunction

  // Count every failure, print only the first ten.
  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Cell driver: feed s_axis from the queue, honoring each cell's idle lead-in
  // ---------------------------------------------------------------------------
  screen_cell_t cells_to_send[$];
  screen_cell_t cell_on_bus;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      // Predict at the edge where the cell transaction completes.
      if (s_axis_tvalid && s_axis_tready) diff_and_track(cell_on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cells_to_send.size() != 0 && cells_to_send[0].gap != 0) begin
          // Stay idle ahead of the next cell, counting down its lead-in.
          cells_to_send[0].gap--;
          s_axis_tvalid <= 1'b0;
        end else if (cells_to_send.size() != 0) begin
          cell_on_bus = cells_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b000, cell_on_bus.freset, cell_on_bus.bulk,
                            cell_on_bus.birth, cell_on_bus.rgb,
                            cell_on_bus.quiet_req, cell_on_bus.col, cell_on_bus.sel,
                            cell_on_bus.bright, cell_on_bus.glyph};
          s_axis_tlast  <= cell_on_bus.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Report monitor: random back-pressure, compare against the oldest report
  // ---------------------------------------------------------------------------
  int unsigned rx_stall_max = GAP_MAX;

  always @(posedge clk_i or negedge rst_ni) begin : report_monitor
    int unsigned stall_left;
    result_t     seen;
    result_t     want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.kind        = result_kind_e'(m_axis_tuser[0]);
        seen.first_index = m_axis_tdata[13:0];
        seen.last_index  = m_axis_tdata[27:14];
        seen.full_upload = m_axis_tdata[28];
        seen.dirty_count = m_axis_tdata[43:29];
        seen.end_of_run  = m_axis_tlast;
        if (upload_reports.size() == 0) begin
          note_failure({"report with nothing expected: ", describe(seen)});
        end else begin
          want = upload_reports.pop_front();
          if (seen !== want)
            note_failure({"report mismatch: expected ", describe(want),
                          " got ", describe(seen)});
        end
        stall_left = $urandom_range(0, rx_stall_max);
      end
      // Hold tready low for the drawn stall, then keep it high.
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when no transaction of any kind completes for long
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  // Last values sent per cell index, so a cell can be repeated unchanged.
  logic [15:0] scene_glyph  [CELL_CAPACITY];
  logic [15:0] scene_bright [CELL_CAPACITY];
  logic        scene_sel    [CELL_CAPACITY];
  logic        scene_col    [CELL_CAPACITY];
  logic [23:0] scene_rgb    [CELL_CAPACITY];
  int unsigned gen_idx = 0;

  task automatic push_cell(input logic [15:0] glyph, input logic [15:0] bright,
                           input logic sel, input logic col, input logic qreq,
                           input logic [23:0] rgb, input logic [31:0] birth,
                           input logic bulk, input logic freset, input logic last,
                           input int unsigned gap);
    screen_cell_t c;
    c.glyph     = glyph;
    c.bright    = bright;
    c.sel       = sel;
    c.col       = col;
    c.quiet_req = qreq;
    c.rgb       = rgb;
    c.birth     = birth;
    c.bulk      = bulk;
    c.freset    = freset;
    c.last      = last;
    c.gap       = gap;
    cells_to_send.insert(cells_to_send.size(), c);
    scene_glyph[gen_idx]  = glyph;
    scene_bright[gen_idx] = bright;
    scene_sel[gen_idx]    = sel;
    scene_col[gen_idx]    = col;
    scene_rgb[gen_idx]    = rgb;
    // Track the index the block will use; it sticks at the last entry.
    if (last) gen_idx = 0;
    else if (gen_idx < CELL_CAPACITY - 1) gen_idx++;
  endtask

  // Repeat what this index last showed: never counts as a change.
  task automatic push_same(input logic bulk, input logic freset, input logic last);
    push_cell(scene_glyph[gen_idx], scene_bright[gen_idx], scene_sel[gen_idx],
              scene_col[gen_idx], 1'($urandom_range(0, 1)), scene_rgb[gen_idx],
              $urandom, bulk, freset, last, $urandom_range(0, GAP_MAX));
  endtask

  // Queue one frame of random cells; most cells repeat or touch a single field
  // so that changed cells are spread out and ranges split and merge.
  task automatic queue_frame(input int unsigned ncells, input bit burst);
    logic        bulk;
    logic        freset;
    logic [15:0] glyph;
    logic [15:0] bright;
    logic        sel;
    logic        col;
    logic [23:0] rgb;
    int unsigned b;
    int unsigned delta;
    bulk   = ($urandom_range(0, 3) == 0);
    freset = ($urandom_range(0, 7) == 0);
    for (int unsigned n = 0; n < ncells; n++) begin
      glyph  = scene_glyph[gen_idx];
      bright = scene_bright[gen_idx];
      sel    = scene_sel[gen_idx];
      col    = scene_col[gen_idx];
      rgb    = scene_rgb[gen_idx];
      case ($urandom_range(0, 9))
        4: glyph = 16'($urandom);
        5: bright = 16'($urandom);
        6: begin
          // Step brightness by exactly the threshold or one past it.
          b     = bright;
          delta = cfg_bright_thr + $urandom_range(0, 1);
          if (b + delta <= 65535) b = b + delta;
          else if (b >= delta) b = b - delta;
          bright = 16'(b);
        end
        7: {sel, col} = 2'($urandom);
        8: rgb = 24'($urandom);
        9: begin
          glyph  = 16'($urandom);
          bright = 16'($urandom);
          {sel, col} = 2'($urandom);
          rgb    = 24'($urandom);
        end
        default: ;  // repeat the cell unchanged
      endcase
      push_cell(glyph, bright, sel, col, 1'($urandom_range(0, 1)), rgb, $urandom,
                bulk, freset | ($urandom_range(0, 39) == 0), n == ncells - 1,
                burst ? 0 : $urandom_range(0, GAP_MAX));
    end
  endtask

  // Write one register over the config channel and mirror it in the predictor.
  task automatic write_reg(input cfg_index_e idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_BRIGHT_THR: cfg_bright_thr = value;
      CFG_RANGE_GAP:  cfg_range_gap  = value[9:0];
      CFG_MAX_RANGES: cfg_max_ranges = value[RTOT_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] thr, input logic [9:0] gap,
                            input logic [RTOT_W-1:0] max_rng);
    write_reg(CFG_BRIGHT_THR, thr);
    write_reg(CFG_RANGE_GAP, CFG_DATA_W'(gap));
    write_reg(CFG_MAX_RANGES, CFG_DATA_W'(max_rng));
  endtask

  // Hold the sender until every owed report is back, then let the pipeline
  // settle before the next config change.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (cells_to_send.size() != 0 || s_axis_tvalid || upload_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned queued;
    int unsigned n;
    foreach (sh_glyph[k]) begin
      sh_glyph[k]      = '0;
      sh_prev_glyph[k] = '0;
      sh_birth[k]      = '0;
      sh_bright[k]     = '0;
      sh_flags[k]      = '0;
      sh_rgb[k]        = '0;
      scene_glyph[k]   = '0;
      scene_bright[k]  = '0;
      scene_sel[k]     = 1'b0;
      scene_col[k]     = 1'b0;
      scene_rgb[k]     = '0;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: a gap of one so ranges split after a single quiet cell.
    set_config(16'd131, 10'd1, 7'd64);
    @(negedge clk_i);
    // All-ones cell with quiet request outside a bulk repaint, two unchanged
    // cells, then a change on the last cell: gap-closed range, final range
    // and summary come out of one cell.
    push_cell(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 24'hFFFFFF, 32'hFFFFFFFF,
              1'b0, 1'b0, 1'b0, $urandom_range(0, GAP_MAX));
    push_cell('0, '0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0);
    push_cell('0, '0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0,
              $urandom_range(0, GAP_MAX));
    push_cell(16'h1234, 16'h8000, 1'b0, 1'b1, 1'b0, 24'h00FF00, 32'h0,
              1'b0, 1'b0, 1'b1, $urandom_range(0, GAP_MAX));
    // Single-cell frame under frame reset; brightness moves by less than the
    // threshold and the held quiet bit keeps the flags equal.
    push_cell(16'hFFFF, 16'hFF9B, 1'b1, 1'b1, 1'b0, 24'hFFFFFF, 32'h0,
              1'b0, 1'b1, 1'b1, 0);
    // Bulk repaint frame: glyph change with quiet request drops quiet,
    // brightness exactly at and one past the threshold, color-only and
    // select-only changes.
    push_cell(16'h0000, 16'hFF9B, 1'b1, 1'b1, 1'b1, 24'hFFFFFF, 32'h89ABCDEF,
              1'b1, 1'b0, 1'b0, $urandom_range(0, GAP_MAX));
    push_cell('0, 16'd131, 1'b0, 1'b0, 1'b0, '0, '0, 1'b1, 1'b0, 1'b0, 0);
    push_cell('0, 16'd132, 1'b0, 1'b0, 1'b1, '0, '0, 1'b1, 1'b0, 1'b0,
              $urandom_range(0, GAP_MAX));
    push_cell(16'h1234, 16'h8000, 1'b0, 1'b1, 1'b0, 24'h000000, '0,
              1'b1, 1'b0, 1'b0, 0);
    push_cell('0, '0, 1'b1, 1'b0, 1'b0, '0, '0, 1'b1, 1'b0, 1'b1,
              $urandom_range(0, GAP_MAX));
    wait_drained();

    // Range budget of one: later ranges are dropped and force a full upload.
    set_config(16'd131, 10'd1, 7'd1);
    @(negedge clk_i);
    push_cell(16'h0001, '0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0);
    push_same(1'b0, 1'b0, 1'b0);
    push_same(1'b0, 1'b0, 1'b0);
    push_cell(16'hFFFF, '0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 0);
    push_same(1'b0, 1'b0, 1'b0);
    push_same(1'b0, 1'b0, 1'b0);
    push_cell(16'h00AA, '0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b1, 0);
    wait_drained();

    // Random part, one register setting per phase with the extremes first.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(16'd0, 10'd0, 7'd1);
        1: set_config(16'hFFFF, 10'd1023, 7'd64);
        2: set_config(16'($urandom), 10'($urandom_range(0, 40)),
                      RTOT_W'($urandom_range(2, 6)));
        3: set_config(16'd131, 10'd3, 7'd2);
        default: set_config(16'($urandom), 10'($urandom),
                            RTOT_W'($urandom_range(1, 64)));
      endcase
      // Phase 0 runs without any idling on either side.
      if (p == 0) rx_stall_max = 0;
      else if (p == 1) rx_stall_max = GAP_MAX;
      else rx_stall_max = $urandom_range(0, 1) ? GAP_MAX : 0;
      @(negedge clk_i);
      queued = 0;
      while (queued < 35) begin
        n = $urandom_range(1, 25);
        queue_frame(n, p == 0 || $urandom_range(0, 3) == 0);
        queued += n;
      end
      wait_drained();
    end

    if (upload_reports.size() != 0)
      note_failure($sformatf("%0d reports never arrived", upload_reports.size()));
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
